### sv/bhd_pkg.sv
// ----------------------------------------------------------------------------
// bhd_pkg: shared widths and types for the box corner distance block
// Field widths, internal datapath widths and the queue status bundle.
// ----------------------------------------------------------------------------
package bhd_pkg;

  localparam int COORD_BITS     = 12;
  localparam int FRAC_BITS      = 4;
  localparam int SIZE_BITS      = COORD_BITS + 1;
  localparam int EDGE_BITS      = COORD_BITS + 2;   // right / bottom edge
  localparam int GAP_BITS       = EDGE_BITS;
  localparam int SQ_BITS        = 2 * GAP_BITS;
  localparam int D2_BITS        = SQ_BITS + 1;
  localparam int OUT_BITS       = COORD_BITS + FRAC_BITS + 1;
  localparam int RAD_BITS       = D2_BITS + 2 * FRAC_BITS;
  localparam int ROOT_BITS      = (RAD_BITS + 1) / 2;
  localparam int RAD_PAD_BITS   = 2 * ROOT_BITS;
  localparam int REM_BITS       = ROOT_BITS + 3;

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + 4 * SIZE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int QDEPTH         = 4;                // power of two
  localparam int QPTR_BITS      = $clog2(QDEPTH);

  typedef struct packed {
    logic [EDGE_BITS-1:0] left;
    logic [EDGE_BITS-1:0] top;
    logic [EDGE_BITS-1:0] right;
    logic [EDGE_BITS-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // distance from p to the closed span [lo, hi], zero inside
  function automatic logic [GAP_BITS-1:0] axis_gap(
    input logic [EDGE_BITS-1:0] p,
    input logic [EDGE_BITS-1:0] lo,
    input logic [EDGE_BITS-1:0] hi
  );
    logic [GAP_BITS-1:0] g;
    if (p < lo) begin
      g = lo - p;
    end else if (p > hi) begin
      g = p - hi;
    end else begin
      g = '0;
    end
    return g;
  endfunction

endpackage

### sv/bhd_front.sv
// ----------------------------------------------------------------------------
// bhd_front: box decode and squared corner distance pipeline
// Six stages from the input beat to the larger of the two corner minima.
// ----------------------------------------------------------------------------
module bhd_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [bhd_pkg::IN_FIELD_BITS-1:0]       in_data_i,
  input  bhd_pkg::queue_status_t                  q_status_i,
  output logic                                    push_o,
  output logic [bhd_pkg::D2_BITS-1:0]             push_data_o
);

  localparam int NSTG = 6;

  logic                              en;
  logic [NSTG-1:0]                   vld_q;

  bhd_pkg::box_t                     box_d [2];
  bhd_pkg::box_t                     box_q [2];
  logic [bhd_pkg::GAP_BITS-1:0]      gap_q [2][4];  // dx left, dx right, dy top, dy bottom
  logic [bhd_pkg::SQ_BITS-1:0]       sq_q  [2][4];
  logic [bhd_pkg::D2_BITS-1:0]       sum_q [2][4];
  logic [bhd_pkg::D2_BITS-1:0]       pmin_q[2][2];
  logic [bhd_pkg::D2_BITS-1:0]       min_q [2];

  logic [bhd_pkg::COORD_BITS-1:0]    f_x [2];
  logic [bhd_pkg::COORD_BITS-1:0]    f_y [2];
  logic [bhd_pkg::SIZE_BITS-1:0]     f_w [2];
  logic [bhd_pkg::SIZE_BITS-1:0]     f_h [2];

  // stall only when the queue is full and the last stage holds a beat
  assign en         = !(vld_q[NSTG-1] && q_status_i.full);
  assign in_ready_o = en;
  assign push_o     = vld_q[NSTG-1] && !q_status_i.full;
  assign push_data_o = (min_q[0] > min_q[1]) ? min_q[0] : min_q[1];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      f_x[b] = in_data_i[b*(bhd_pkg::IN_FIELD_BITS/2) +: bhd_pkg::COORD_BITS];
      f_y[b] = in_data_i[b*(bhd_pkg::IN_FIELD_BITS/2) + bhd_pkg::COORD_BITS
                         +: bhd_pkg::COORD_BITS];
      f_w[b] = in_data_i[b*(bhd_pkg::IN_FIELD_BITS/2) + 2*bhd_pkg::COORD_BITS
                         +: bhd_pkg::SIZE_BITS];
      f_h[b] = in_data_i[b*(bhd_pkg::IN_FIELD_BITS/2) + 2*bhd_pkg::COORD_BITS
                         + bhd_pkg::SIZE_BITS +: bhd_pkg::SIZE_BITS];
      // zero size counts as one pixel, so the far edge equals the near one
      box_d[b].left   = bhd_pkg::EDGE_BITS'(f_x[b]);
      box_d[b].top    = bhd_pkg::EDGE_BITS'(f_y[b]);
      box_d[b].right  = (f_w[b] == '0) ? bhd_pkg::EDGE_BITS'(f_x[b]) :
                        bhd_pkg::EDGE_BITS'(f_x[b]) + bhd_pkg::EDGE_BITS'(f_w[b])
                        - bhd_pkg::EDGE_BITS'(1);
      box_d[b].bottom = (f_h[b] == '0) ? bhd_pkg::EDGE_BITS'(f_y[b]) :
                        bhd_pkg::EDGE_BITS'(f_y[b]) + bhd_pkg::EDGE_BITS'(f_h[b])
                        - bhd_pkg::EDGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      box_q[0] <= box_d[0];
      box_q[1] <= box_d[1];
      for (int d = 0; d < 2; d++) begin
        // d = 0: corners of the first box against the second, d = 1: reverse
        gap_q[d][0] <= bhd_pkg::axis_gap(box_q[d].left,   box_q[1-d].left,
                                         box_q[1-d].right);
        gap_q[d][1] <= bhd_pkg::axis_gap(box_q[d].right,  box_q[1-d].left,
                                         box_q[1-d].right);
        gap_q[d][2] <= bhd_pkg::axis_gap(box_q[d].top,    box_q[1-d].top,
                                         box_q[1-d].bottom);
        gap_q[d][3] <= bhd_pkg::axis_gap(box_q[d].bottom, box_q[1-d].top,
                                         box_q[1-d].bottom);
        for (int k = 0; k < 4; k++) begin
          sq_q[d][k] <= bhd_pkg::SQ_BITS'(gap_q[d][k]) * bhd_pkg::SQ_BITS'(gap_q[d][k]);
        end
        sum_q[d][0] <= bhd_pkg::D2_BITS'(sq_q[d][0]) + bhd_pkg::D2_BITS'(sq_q[d][2]);
        sum_q[d][1] <= bhd_pkg::D2_BITS'(sq_q[d][0]) + bhd_pkg::D2_BITS'(sq_q[d][3]);
        sum_q[d][2] <= bhd_pkg::D2_BITS'(sq_q[d][1]) + bhd_pkg::D2_BITS'(sq_q[d][2]);
        sum_q[d][3] <= bhd_pkg::D2_BITS'(sq_q[d][1]) + bhd_pkg::D2_BITS'(sq_q[d][3]);
        pmin_q[d][0] <= (sum_q[d][1] < sum_q[d][0]) ? sum_q[d][1] : sum_q[d][0];
        pmin_q[d][1] <= (sum_q[d][3] < sum_q[d][2]) ? sum_q[d][3] : sum_q[d][2];
        min_q[d]     <= (pmin_q[d][1] < pmin_q[d][0]) ? pmin_q[d][1] : pmin_q[d][0];
      end
    end
  end

endmodule

### sv/bhd_queue.sv
// ----------------------------------------------------------------------------
// bhd_queue: short FIFO between distance pipeline and square root
// Four entries of squared distance; status is registered count only.
// ----------------------------------------------------------------------------
module bhd_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [bhd_pkg::D2_BITS-1:0]   push_data_i,
  input  logic                          pop_i,
  output logic [bhd_pkg::D2_BITS-1:0]   pop_data_o,
  output bhd_pkg::queue_status_t        status_o
);

  logic [bhd_pkg::D2_BITS-1:0]     mem_q [bhd_pkg::QDEPTH];
  logic [bhd_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [bhd_pkg::QPTR_BITS:0]     cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == (bhd_pkg::QPTR_BITS+1)'(bhd_pkg::QDEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (bhd_pkg::QPTR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (bhd_pkg::QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + bhd_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + bhd_pkg::QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/bhd_sqrt.sv
// ----------------------------------------------------------------------------
// bhd_sqrt: pipelined integer square root with output register
// One root bit per stage on the scaled squared distance, then saturation.
// ----------------------------------------------------------------------------
module bhd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bhd_pkg::queue_status_t        q_status_i,
  input  logic [bhd_pkg::D2_BITS-1:0]   q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bhd_pkg::OUT_BITS-1:0]  out_data_o
);

  localparam int N = bhd_pkg::ROOT_BITS;

  logic                                en;
  logic [N-1:0]                        vld_q;
  logic                                out_vld_q;
  logic [bhd_pkg::OUT_BITS-1:0]        out_q;

  logic [bhd_pkg::REM_BITS-1:0]        rem_q  [N];
  logic [bhd_pkg::ROOT_BITS-1:0]       root_q [N];
  logic [bhd_pkg::RAD_PAD_BITS-1:0]    val_q  [N];

  logic [bhd_pkg::REM_BITS-1:0]        rem_d  [N];
  logic [bhd_pkg::ROOT_BITS-1:0]       root_d [N];
  logic [bhd_pkg::RAD_PAD_BITS-1:0]    val_d  [N];

  logic [bhd_pkg::REM_BITS-1:0]        src_rem;
  logic [bhd_pkg::ROOT_BITS-1:0]       src_root;
  logic [bhd_pkg::RAD_PAD_BITS-1:0]    src_val;
  logic [bhd_pkg::REM_BITS-1:0]        cur, trial;
  logic [bhd_pkg::ROOT_BITS-1:0]       last_root;

  assign en          = !out_vld_q || out_ready_i;
  assign pop_o       = en && !q_status_i.empty;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign last_root   = root_q[N-1];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        src_rem  = '0;
        src_root = '0;
        src_val  = bhd_pkg::RAD_PAD_BITS'({q_data_i, {(2*bhd_pkg::FRAC_BITS){1'b0}}});
      end else begin
        src_rem  = rem_q[i-1];
        src_root = root_q[i-1];
        src_val  = val_q[i-1];
      end
      cur   = {src_rem[bhd_pkg::REM_BITS-3:0],
               src_val[bhd_pkg::RAD_PAD_BITS-1 -: 2]};
      trial = bhd_pkg::REM_BITS'({src_root, 2'b01});
      if (cur >= trial) begin
        rem_d[i]  = cur - trial;
        root_d[i] = {src_root[bhd_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d[i]  = cur;
        root_d[i] = {src_root[bhd_pkg::ROOT_BITS-2:0], 1'b0};
      end
      val_d[i] = {src_val[bhd_pkg::RAD_PAD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[N-2:0], !q_status_i.empty};
      out_vld_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        val_q[i]  <= val_d[i];
      end
      // clamp to the all-ones output code when the root is too wide
      if (|last_root[bhd_pkg::ROOT_BITS-1:bhd_pkg::OUT_BITS]) begin
        out_q <= '1;
      end else begin
        out_q <= last_root[bhd_pkg::OUT_BITS-1:0];
      end
    end
  end

endmodule

### sv/bbox_hausdorff_distance_top.sv
// ----------------------------------------------------------------------------
// bbox_hausdorff_distance_top: corner distance between two boxes
// Front pipeline, decoupling queue and square root back end.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat carries both boxes (x, y, width, height each).
//   Master stream: one beat per input beat, the distance in unsigned fixed
//   point with four fraction bits, rounded down, clamped to all ones.
//   Throughput: one beat per cycle while m_axis_tready stays high, set by
//   fully pipelined datapaths on both sides (one root bit per back-end stage).
//   Path: 6 front stages, the decoupling queue, 19 root stages and the
//   output register.
//   Reset: all valid bits and the queue empty; no payload is cleared.
//   Receiver stall: the back end holds while the output beat waits; the
//   four-entry queue then fills, and only after that does the front stop
//   and s_axis_tready fall. s_axis_tready never depends on m_axis_tready
//   in the same cycle.
//   Work is stateless: every beat is independent of the ones before.
// ----------------------------------------------------------------------------
module bbox_hausdorff_distance_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // first_x, first_y, first_width, first_height,
  // second_x, second_y, second_width, second_height, zero pad
  input  logic [bhd_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // distance, zero pad
  output logic [bhd_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata
);

  bhd_pkg::queue_status_t               q_status;
  logic                                 push, pop;
  logic [bhd_pkg::D2_BITS-1:0]          push_data, pop_data;
  logic [bhd_pkg::OUT_BITS-1:0]         distance;

  // squared distances, max of the two corner minima
  bhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata[bhd_pkg::IN_FIELD_BITS-1:0]),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bhd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // square root of d2 scaled by 2^(2*frac) gives the fixed-point distance
  bhd_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (distance)
  );

  assign m_axis_tdata = bhd_pkg::OUT_TDATA_BITS'(distance);

endmodule
